>>> design/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
// Used by dltq_ctrl, dltq_dp and delta_list_timer_queue; depends on nothing.
package dltq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

  localparam int DELTA_W  = 16;
  localparam int ACTION_W = 8;
  localparam int ARG_W    = 32;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_FULL   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_WALK,
    ST_INS_COMMIT,
    ST_TICK_SEEK,
    ST_FIRE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  walk_step;
    logic  dec;
    logic  commit;
    logic  pop;
    logic  emit;
    kind_t kind;
    logic  last;
    logic  from_head;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic busy;
    logic full;
    logic empty;
    logic idx_at_count;
    logic delta_zero;
    logic walk_go;
    logic fire_ok;
    logic head_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/dltq_dp.sv
// Datapath of the delta-list timer queue: entry registers, walk index,
// remaining delay, fire counter and the output register. Depends on dltq_pkg.
module dltq_dp import dltq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  in_mode,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [ARG_W-1:0]      in_argument,
  input  logic [DELTA_W-1:0]    in_delay,
  input  logic                  in_busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kind_t                 out_kind,
  output logic [ACTION_W-1:0]   out_action,
  output logic [ARG_W-1:0]      out_argument,
  output logic                  out_last
);

  logic [DELTA_W-1:0]  delta_r  [QUEUE_DEPTH];
  logic [ACTION_W-1:0] action_r [QUEUE_DEPTH];
  logic [ARG_W-1:0]    arg_r    [QUEUE_DEPTH];

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    idx_r;
  logic [FIRED_W-1:0]  fired_r;
  logic [DELTA_W-1:0]  t_r;
  logic                mode_r;
  logic                busy_r;
  logic [ACTION_W-1:0] new_action_r;
  logic [ARG_W-1:0]    new_arg_r;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [ACTION_W-1:0] out_action_r;
  logic [ARG_W-1:0]    out_arg_r;
  logic                out_last_r;

  logic [DELTA_W-1:0]  delta_sel;
  logic [DELTA_W-1:0]  delta_rem;
  logic                out_free;

  assign delta_sel = delta_r[idx_r[IDX_W-1:0]];
  assign delta_rem = delta_sel - t_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    status.mode         = mode_r;
    status.busy         = busy_r;
    status.full         = (count_r == CNT_W'(QUEUE_DEPTH));
    status.empty        = (count_r == '0);
    status.idx_at_count = (idx_r == count_r);
    status.delta_zero   = (delta_sel == '0);
    status.walk_go      = (idx_r != count_r) && (delta_sel <= t_r);
    status.fire_ok      = (count_r != '0) && (fired_r < FIRED_W'(MAX_RESULTS))
                          && (delta_r[0] == '0);
    status.head_last    = (count_r == CNT_W'(1))
                          || (fired_r == FIRED_W'(MAX_RESULTS - 1))
                          || (delta_r[1] != '0);
    status.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r       <= in_mode;
      busy_r       <= in_busy;
      t_r          <= in_delay;
      new_action_r <= in_action;
      new_arg_r    <= in_argument;
    end else if (cmd.walk_step) begin
      t_r <= t_r - delta_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      fired_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r   <= '0;
        fired_r <= '0;
      end else if (cmd.walk_step) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.commit) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CNT_W'(1);
        fired_r <= fired_r + FIRED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (cmd.commit) begin
        if (CNT_W'(j) == idx_r) begin
          delta_r[j]  <= t_r;
          action_r[j] <= new_action_r;
          arg_r[j]    <= new_arg_r;
        end else if (j > 0 && CNT_W'(j) > idx_r) begin
          delta_r[j]  <= (CNT_W'(j) == idx_r + CNT_W'(1)) ? delta_rem : delta_r[j-1];
          action_r[j] <= action_r[j-1];
          arg_r[j]    <= arg_r[j-1];
        end
      end else if (cmd.pop) begin
        if (j < QUEUE_DEPTH - 1) begin
          delta_r[j]  <= delta_r[j+1];
          action_r[j] <= action_r[j+1];
          arg_r[j]    <= arg_r[j+1];
        end
      end else if (cmd.dec && CNT_W'(j) == idx_r) begin
        delta_r[j] <= delta_r[j] - DELTA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_last_r   <= cmd.last;
      out_action_r <= cmd.from_head ? action_r[0] : '0;
      out_arg_r    <= cmd.from_head ? arg_r[0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_action   = out_action_r;
  assign out_argument = out_arg_r;
  assign out_last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from an empty queue");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insert committed into a full queue");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result written over a beat not yet taken");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not lower the entry count");

endmodule

>>> design/dltq_ctrl.sv
// Controller of the delta-list timer queue: sequences insert walks, tick
// decrements and entry firing. Depends on dltq_pkg.
module dltq_ctrl import dltq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = KIND_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.mode) begin
          if (!status.full) begin
            state_nxt = ST_INS_WALK;
          end else if (status.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_FULL;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (!status.empty) begin
            state_nxt = ST_TICK_SEEK;
          end else if (status.out_free) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INS_WALK: begin
        if (status.walk_go) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = ST_INS_COMMIT;
        end
      end
      ST_INS_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_ACCEPT;
          cmd.last   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_TICK_SEEK: begin
        if (status.idx_at_count) begin
          state_nxt = ST_FIRE;
        end else if (!status.delta_zero) begin
          cmd.dec   = 1'b1;
          state_nxt = ST_FIRE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_FIRE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!status.busy && status.fire_ok) begin
            cmd.pop       = 1'b1;
            cmd.kind      = KIND_FIRED;
            cmd.from_head = 1'b1;
            cmd.last      = status.head_last;
            if (status.head_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE))
    else $error("item taken outside the idle state");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == ST_IDLE))
    else $error("final beat not followed by idle");

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.commit, cmd.pop, cmd.dec}) <= 1)
    else $error("conflicting queue updates in one cycle");

endmodule

>>> design/delta_list_timer_queue.sv
// Delta-list timer queue: a sorted callout queue whose expiry times are kept
// as deltas. Top level; depends on dltq_pkg, dltq_ctrl and dltq_dp.
//
// The input channel carries one command per beat: in_tuser = 1 inserts a new
// entry (action_id, argument, delay), in_tuser = 0 is a clock tick, with
// priority_busy deferring any firing to a later tick. The output channel
// returns one or more beats per command; out_tuser gives the kind of result
// and out_tlast marks the final beat of the command.
// A command is taken only while the block is idle. An insert walks past each
// entry whose delta does not exceed its remaining delay, then commits the new
// entry and returns an accept beat. An insert into a full queue and a tick on
// an empty queue answer straight from the dispatch state. Any other tick skips
// leading zero-delta entries, decrements the first nonzero delta if there is
// one and then returns its result beats, using the same single walk index.
// Reset empties the queue and clears any pending result. A stalled receiver
// holds the current result in the output register and the controller waits;
// a new command can be taken while the final beat of the previous one still
// waits to be taken.
module delta_list_timer_queue import dltq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // action_id, argument, delay, priority_busy
  input  logic                  in_tuser,  // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // action_id_res, argument_res
  output logic [1:0]            out_tuser, // kind
  output logic                  out_tlast
);

  dp_cmd_t             cmd;
  dp_status_t          status;
  kind_t               out_kind;
  logic [ACTION_W-1:0] out_action;
  logic [ARG_W-1:0]    out_argument;

  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dltq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_mode      (in_tuser),
    .in_action    (in_tdata[7:0]),
    .in_argument  (in_tdata[39:8]),
    .in_delay     (in_tdata[55:40]),
    .in_busy      (in_tdata[56]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_kind),
    .out_action   (out_action),
    .out_argument (out_argument),
    .out_last     (out_tlast)
  );

  assign out_tdata = {out_argument, out_action};
  assign out_tuser = out_kind;

endmodule
